// ===== design/desu_pkg.sv =====
// Shared types and constants of the dual-exponential synapse unit.
package desu_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COEF_WIDTH = 32;
  localparam int REG_COUNT  = 6;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_SPIKE  = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_WAIT
  } state_e;

  // Product sequence of a tick, then the random spike test. Each code also
  // selects the configuration register that holds its coefficient.
  localparam logic [2:0] STEP_RISE_IN   = 3'd0;
  localparam logic [2:0] STEP_RISE_RET  = 3'd1;
  localparam logic [2:0] STEP_DECAY_IN  = 3'd2;
  localparam logic [2:0] STEP_DECAY_RET = 3'd3;
  localparam logic [2:0] STEP_NORM      = 3'd4;
  localparam logic [2:0] STEP_SPIKE     = 3'd5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] weight;
    logic [31:0]        event_rate;
    logic [31:0]        random_draw;
  } req_t;

  typedef struct packed {
    logic signed [31:0] conductance;
    logic signed [31:0] rise_value;
  } rsp_t;

endpackage

// ===== design/desu_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
interface desu_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/dual_exponential_synapse_unit.sv =====
// Dual-exponential synapse: serial shift-add datapath, control sequencer and result register.
//
// Weight and clear beats are applied as they are taken, and the input stays
// open. A random spike beat runs one product through the bit-serial
// multiplier, which keeps the input closed until the product is done.
// A tick runs five products back to back (activation and rise into rise, old
// rise and decay into decay, decay into conductance), each a load state, a
// serial multiply and a round-and-accumulate state. The result then passes
// from the wait state into the output register, and the next beat can be
// taken after that. Each product's length is set by the multiplier, which
// consumes one coefficient bit per cycle and adds the multiplicand into a
// partial product that shifts right as it goes. The result register is freed
// as soon as the sink takes the beat; a tick that finishes while the previous
// result is still held waits in place.
module dual_exponential_synapse_unit #(
  parameter int DATA_WIDTH = desu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = desu_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [desu_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [desu_pkg::COEF_WIDTH-1:0]      cfg_data_i,
  desu_stream_if.sink                          req_i,
  desu_stream_if.source                        rsp_o
);

  localparam int DW  = DATA_WIDTH;
  localparam int CW  = desu_pkg::COEF_WIDTH;
  localparam int AW  = (DW > CW + 1) ? DW : CW + 1;
  localparam int PW  = AW + CW + 1;
  localparam int TW  = PW - 16;
  localparam int SW  = TW + 1;
  localparam int BCW = $clog2(CW);

  localparam logic signed [SW-1:0] MAXV = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [PW-1:0] HALF30 = PW'(1) << 29;
  localparam logic signed [PW-1:0] HALF16 = PW'(1) << 15;

  function automatic logic signed [DW-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [DW-1:0] r;
    if (x > MAXV) begin
      r = MAXV[DW-1:0];
    end else if (x < MINV) begin
      r = MINV[DW-1:0];
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

  desu_pkg::state_e state_q, state_d;

  logic [CW-1:0]        cfg_q [desu_pkg::REG_COUNT];
  logic signed [DW-1:0] act_q, act_d;
  logic signed [DW-1:0] rise_q, rise_d;
  logic signed [DW-1:0] decay_q, decay_d;
  logic signed [DW-1:0] cond_q, cond_d;
  logic signed [DW-1:0] rise_new_q, rise_new_d;
  logic signed [TW-1:0] acc_q, acc_d;
  logic [2:0]           step_q, step_d;
  logic [BCW-1:0]       bit_cnt_q, bit_cnt_d;
  logic signed [AW-1:0] mcand_q, mcand_d;
  logic [CW-1:0]        mplier_q, mplier_d;
  logic signed [AW:0]   p_hi_q, p_hi_d;
  logic [CW-1:0]        p_lo_q, p_lo_d;
  logic signed [DW-1:0] spk_weight_q, spk_weight_d;
  logic [31:0]          rate_q, rate_d;
  logic [31:0]          draw_q, draw_d;
  logic                 rsp_valid_q, rsp_valid_d;
  desu_pkg::rsp_t       rsp_q, rsp_d;

  logic                 req_fire;
  logic                 rsp_free;
  logic signed [DW-1:0] w_sat;
  logic signed [DW-1:0] act_plus_w;
  logic signed [DW-1:0] act_plus_spk;
  logic signed [AW+1:0] mul_sum;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd30;
  logic signed [PW-1:0] rnd16;
  logic signed [TW-1:0] term;
  logic signed [DW-1:0] pair_sat;
  logic [PW-1:0]        draw_ext;
  logic                 spike_hit;

  assign req_i.ready = (state_q == desu_pkg::ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;

  assign w_sat        = sat(SW'(req_i.data.weight));
  assign act_plus_w   = sat(SW'(act_q) + SW'(w_sat));
  assign act_plus_spk = sat(SW'(act_q) + SW'(spk_weight_q));

  // One serial multiply step: add the multiplicand when the coefficient bit is
  // set, then shift the partial product right by one into the low word.
  assign mul_sum = (AW+2)'(p_hi_q) + (mplier_q[0] ? (AW+2)'(mcand_q) : '0);

  assign prod  = $signed({p_hi_q, p_lo_q});
  assign rnd30 = (prod + HALF30) >>> 30;
  assign rnd16 = (prod + HALF16) >>> 16;
  assign term  = (step_q == desu_pkg::STEP_NORM) ? rnd16[TW-1:0] : rnd30[TW-1:0];
  assign pair_sat = sat(SW'(acc_q) + SW'(term));

  assign draw_ext  = PW'(draw_q) << FRAC_BITS;
  assign spike_hit = ($unsigned(prod) >= draw_ext);

  always_comb begin
    state_d = state_q;
    case (state_q)
      desu_pkg::ST_IDLE: begin
        if (req_fire && (req_i.data.req_type == desu_pkg::REQ_TICK ||
                         req_i.data.req_type == desu_pkg::REQ_SPIKE)) begin
          state_d = desu_pkg::ST_LOAD;
        end
      end
      desu_pkg::ST_LOAD: state_d = desu_pkg::ST_MUL;
      desu_pkg::ST_MUL: begin
        if (bit_cnt_q == BCW'(CW - 1)) begin
          state_d = desu_pkg::ST_ACC;
        end
      end
      desu_pkg::ST_ACC: begin
        case (step_q)
          desu_pkg::STEP_NORM:  state_d = desu_pkg::ST_WAIT;
          desu_pkg::STEP_SPIKE: state_d = desu_pkg::ST_IDLE;
          default:              state_d = desu_pkg::ST_LOAD;
        endcase
      end
      desu_pkg::ST_WAIT: begin
        if (rsp_free) begin
          state_d = desu_pkg::ST_IDLE;
        end
      end
      default: state_d = desu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    act_d        = act_q;
    rise_d       = rise_q;
    decay_d      = decay_q;
    cond_d       = cond_q;
    rise_new_d   = rise_new_q;
    acc_d        = acc_q;
    step_d       = step_q;
    bit_cnt_d    = bit_cnt_q;
    mcand_d      = mcand_q;
    mplier_d     = mplier_q;
    p_hi_d       = p_hi_q;
    p_lo_d       = p_lo_q;
    spk_weight_d = spk_weight_q;
    rate_d       = rate_q;
    draw_d       = draw_q;
    rsp_d        = rsp_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;

    case (state_q)
      desu_pkg::ST_IDLE: begin
        if (req_fire) begin
          case (req_i.data.req_type)
            desu_pkg::REQ_WEIGHT: act_d = act_plus_w;
            desu_pkg::REQ_SPIKE: begin
              step_d       = desu_pkg::STEP_SPIKE;
              spk_weight_d = w_sat;
              rate_d       = req_i.data.event_rate;
              draw_d       = req_i.data.random_draw;
            end
            desu_pkg::REQ_TICK: step_d = desu_pkg::STEP_RISE_IN;
            desu_pkg::REQ_CLEAR: begin
              act_d   = '0;
              rise_d  = '0;
              decay_d = '0;
              cond_d  = '0;
            end
            default: act_d = act_q;
          endcase
        end
      end
      desu_pkg::ST_LOAD: begin
        p_hi_d    = '0;
        p_lo_d    = '0;
        bit_cnt_d = '0;
        // The step code doubles as the index of its coefficient register.
        mplier_d  = cfg_q[step_q];
        case (step_q)
          desu_pkg::STEP_RISE_IN:   mcand_d = AW'(act_q);
          desu_pkg::STEP_RISE_RET:  mcand_d = AW'(rise_q);
          desu_pkg::STEP_DECAY_IN:  mcand_d = AW'(rise_q);
          desu_pkg::STEP_DECAY_RET: mcand_d = AW'(decay_q);
          desu_pkg::STEP_NORM:      mcand_d = AW'(decay_q);
          default:                  mcand_d = $signed(AW'(rate_q));
        endcase
      end
      desu_pkg::ST_MUL: begin
        p_hi_d    = mul_sum[AW+1:1];
        p_lo_d    = {mul_sum[0], p_lo_q[CW-1:1]};
        mplier_d  = {1'b0, mplier_q[CW-1:1]};
        bit_cnt_d = bit_cnt_q + BCW'(1);
      end
      desu_pkg::ST_ACC: begin
        step_d = step_q + 3'd1;
        case (step_q)
          desu_pkg::STEP_RISE_IN:   acc_d = term;
          desu_pkg::STEP_RISE_RET:  rise_new_d = pair_sat;
          desu_pkg::STEP_DECAY_IN:  acc_d = term;
          desu_pkg::STEP_DECAY_RET: decay_d = pair_sat;
          desu_pkg::STEP_NORM: begin
            cond_d = sat(SW'(term));
            rise_d = rise_new_q;
            act_d  = '0;
          end
          default: begin
            if (spike_hit) begin
              act_d = act_plus_spk;
            end
          end
        endcase
      end
      desu_pkg::ST_WAIT: begin
        if (rsp_free) begin
          rsp_valid_d       = 1'b1;
          rsp_d.conductance = 32'(cond_q);
          rsp_d.rise_value  = 32'(rise_q);
        end
      end
      default: rsp_d = rsp_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= desu_pkg::ST_IDLE;
      rsp_valid_q <= 1'b0;
      act_q       <= '0;
      rise_q      <= '0;
      decay_q     <= '0;
      cond_q      <= '0;
      step_q      <= '0;
      bit_cnt_q   <= '0;
      for (int i = 0; i < desu_pkg::REG_COUNT; i++) begin
        cfg_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      act_q       <= act_d;
      rise_q      <= rise_d;
      decay_q     <= decay_d;
      cond_q      <= cond_d;
      step_q      <= step_d;
      bit_cnt_q   <= bit_cnt_d;
      if (cfg_we_i && (cfg_idx_i < desu_pkg::REG_IDX_W'(desu_pkg::REG_COUNT))) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rise_new_q   <= rise_new_d;
    acc_q        <= acc_d;
    mcand_q      <= mcand_d;
    mplier_q     <= mplier_d;
    p_hi_q       <= p_hi_d;
    p_lo_q       <= p_lo_d;
    spk_weight_q <= spk_weight_d;
    rate_q       <= rate_d;
    draw_q       <= draw_d;
    rsp_q        <= rsp_d;
  end

endmodule

// ===== verif/tb_dual_exponential_synapse_unit.sv =====
// Self-checking bench for the dual-exponential synapse unit: directed rows, then random phases.
module tb_dual_exponential_synapse_unit;

  localparam int          CLK_PERIOD      = 10;
  localparam int          RESET_CYCLES    = 11;
  localparam int          IDLE_PERCENT    = 17;
  localparam int          NUM_PHASES      = 8;
  localparam int          ITEMS_PER_PHASE = 100;
  // Covers any beat still in flight, even a tick, which holds the input longest.
  localparam int          TAIL_CYCLES     = 200;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int          COEF_DROP       = 30;
  localparam int          NORM_DROP       = 16;
  localparam int          FRAC            = desu_pkg::FRAC_BITS_DEF;
  localparam logic [31:0] SMALL_SPAN      = 32'h0020_0000;

  localparam int PHASE_ALL_ONES = 0;
  localparam int PHASE_ALL_ZERO = 1;
  localparam int PHASE_PAUSE    = 2;
  localparam int PHASE_STEADY   = 3;
  localparam int PHASE_UNMAPPED = 4;

  typedef struct packed {
    logic [31:0] rise_in;
    logic [31:0] rise_ret;
    logic [31:0] decay_in;
    logic [31:0] decay_ret;
    logic [31:0] norm;
    logic [31:0] tstep;
  } coef_set_t;

  typedef struct packed {
    desu_pkg::req_type_e kind;
    logic [31:0]         weight;
    logic [31:0]         rate;
    logic [31:0]         draw;
    logic                typed;
    desu_pkg::rsp_t      known;
  } stim_row_t;

  // Unity gains with no retention, so each tick result can be read off directly.
  localparam coef_set_t DIRECTED_COEFS = '{
    rise_in: 32'h4000_0000, rise_ret: 32'h0, decay_in: 32'h4000_0000,
    decay_ret: 32'h0, norm: 32'h0001_0000, tstep: 32'h8000_0000
  };

  // Rows before DIRECTED_CFG_ROW run with the registers as left by reset.
  localparam int DIRECTED_CFG_ROW = 2;
  localparam int DIRECTED_ROWS    = 23;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{desu_pkg::REQ_WEIGHT, 32'h1234_5678, 32'h0,         32'h0,         1'b0, '0},
    '{desu_pkg::REQ_TICK,   32'h0,         32'h0,         32'h0,         1'b1,
      '{32'sh0, 32'sh0}},
    '{desu_pkg::REQ_WEIGHT, 32'h7FFF_FFFF, 32'h0,         32'h0,         1'b0, '0},
    '{desu_pkg::REQ_WEIGHT, 32'h7FFF_FFFF, 32'h0,         32'h0,         1'b0, '0},
    '{desu_pkg::REQ_TICK,   32'h0,         32'h0,         32'h0,         1'b1,
      '{32'sh0, 32'sh7FFF_FFFF}},
    '{desu_pkg::REQ_TICK,   32'h0,         32'h0,         32'h0,         1'b1,
      '{32'sh7FFF_FFFF, 32'sh0}},
    '{desu_pkg::REQ_WEIGHT, 32'h8000_0000, 32'h0,         32'h0,         1'b0, '0},
    '{desu_pkg::REQ_WEIGHT, 32'h8000_0000, 32'h0,         32'h0,         1'b0, '0},
    '{desu_pkg::REQ_TICK,   32'h0,         32'h0,         32'h0,         1'b1,
      '{32'sh0, 32'sh8000_0000}},
    '{desu_pkg::REQ_TICK,   32'h0,         32'h0,         32'h0,         1'b1,
      '{32'sh8000_0000, 32'sh0}},
    '{desu_pkg::REQ_SPIKE,  32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFF, 1'b0, '0},
    '{desu_pkg::REQ_SPIKE,  32'h0010_0000, 32'h0001_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{desu_pkg::REQ_SPIKE,  32'h0000_0001, 32'h0,         32'h0,         1'b0, '0},
    '{desu_pkg::REQ_TICK,   32'h0,         32'h0,         32'h0,         1'b1,
      '{32'sh0, 32'sh0001_0001}},
    '{desu_pkg::REQ_WEIGHT, 32'h0000_0005, 32'h0,         32'h0,         1'b0, '0},
    '{desu_pkg::REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{desu_pkg::REQ_TICK,   32'h0,         32'h0,         32'h0,         1'b1,
      '{32'sh0, 32'sh0}},
    '{desu_pkg::REQ_SPIKE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{desu_pkg::REQ_WEIGHT, 32'h5555_AAAA, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0, '0},
    '{desu_pkg::REQ_WEIGHT, 32'hAAAA_5555, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0, '0},
    '{desu_pkg::REQ_TICK,   32'h0,         32'h0,         32'h0,         1'b0, '0},
    '{desu_pkg::REQ_TICK,   32'h0,         32'h0,         32'h0,         1'b0, '0},
    '{desu_pkg::REQ_CLEAR,  32'h0,         32'h0,         32'h0,         1'b0, '0}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [desu_pkg::REG_IDX_W-1:0]  cfg_idx_i;
  logic [desu_pkg::COEF_WIDTH-1:0] cfg_data_i;

  desu_stream_if #(.T(desu_pkg::req_t)) req_if ();
  desu_stream_if #(.T(desu_pkg::rsp_t)) rsp_if ();

  dual_exponential_synapse_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow copy of the synapse state and its coefficients.
  coef_set_t          coef_now;
  logic signed [31:0] act_q;
  logic signed [31:0] rise_q;
  logic signed [31:0] decay_q;
  logic signed [31:0] cond_q;

  desu_pkg::rsp_t pending_tick_rsp[$];
  int             mismatch_count = 0;
  int unsigned    cycle_count = 0;
  bit             steady_mode = 1'b0;

  function automatic logic signed [31:0] clamp_q16(input logic signed [95:0] x);
    if (x[95:31] == {65{x[95]}}) return x[31:0];
    return x[95] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // Rounds v*c/2^drop to nearest, ties toward plus infinity, with no loss of bits.
  function automatic logic signed [95:0] scaled_product(input logic signed [31:0] v,
                                                        input logic [31:0] c,
                                                        input int unsigned drop);
    logic signed [95:0] vw;
    logic signed [95:0] cw;
    logic signed [95:0] p;
    vw = v;
    cw = $signed({64'd0, c});
    p = vw * cw + (96'sd1 <<< (drop - 1));
    return p >>> drop;
  endfunction

  task automatic model_synapse(input desu_pkg::req_t item, output bit has_rsp,
                               output desu_pkg::rsp_t rsp);
    logic signed [95:0] w_ext;
    logic signed [95:0] act_ext;
    logic [63:0]        lhs;
    logic [63:0]        rhs;
    logic signed [31:0] old_rise;
    has_rsp = 1'b0;
    rsp = '0;
    w_ext = $signed(item.weight);
    act_ext = act_q;
    case (desu_pkg::req_type_e'(item.req_type))
      desu_pkg::REQ_WEIGHT: begin
        act_q = clamp_q16(act_ext + w_ext);
      end
      desu_pkg::REQ_SPIKE: begin
        lhs = {32'd0, item.event_rate} * {32'd0, coef_now.tstep};
        rhs = {32'd0, item.random_draw} << FRAC;
        if (lhs >= rhs) act_q = clamp_q16(act_ext + w_ext);
      end
      desu_pkg::REQ_CLEAR: begin
        act_q = '0;
        rise_q = '0;
        decay_q = '0;
        cond_q = '0;
      end
      default: begin
        old_rise = rise_q;
        rise_q = clamp_q16(scaled_product(act_q, coef_now.rise_in, COEF_DROP) +
                           scaled_product(old_rise, coef_now.rise_ret, COEF_DROP));
        decay_q = clamp_q16(scaled_product(old_rise, coef_now.decay_in, COEF_DROP) +
                            scaled_product(decay_q, coef_now.decay_ret, COEF_DROP));
        cond_q = clamp_q16(scaled_product(decay_q, coef_now.norm, NORM_DROP));
        act_q = '0;
        has_rsp = 1'b1;
        rsp.conductance = cond_q;
        rsp.rise_value = rise_q;
      end
    endcase
  endtask

  task automatic write_reg(input logic [desu_pkg::REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      desu_pkg::STEP_RISE_IN:   coef_now.rise_in = val;
      desu_pkg::STEP_RISE_RET:  coef_now.rise_ret = val;
      desu_pkg::STEP_DECAY_IN:  coef_now.decay_in = val;
      desu_pkg::STEP_DECAY_RET: coef_now.decay_ret = val;
      desu_pkg::STEP_NORM:      coef_now.norm = val;
      desu_pkg::STEP_SPIKE:     coef_now.tstep = val;
      default: ;
    endcase
  endtask

  task automatic load_coefs(input coef_set_t c, input bit with_unmapped);
    write_reg(desu_pkg::STEP_RISE_IN, c.rise_in);
    write_reg(desu_pkg::STEP_RISE_RET, c.rise_ret);
    write_reg(desu_pkg::STEP_DECAY_IN, c.decay_in);
    write_reg(desu_pkg::STEP_DECAY_RET, c.decay_ret);
    write_reg(desu_pkg::STEP_NORM, c.norm);
    write_reg(desu_pkg::STEP_SPIKE, c.tstep);
    if (with_unmapped) begin
      for (int u = desu_pkg::REG_COUNT; u < 2 ** desu_pkg::REG_IDX_W; u++)
        write_reg(desu_pkg::REG_IDX_W'(u), $urandom);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Valid only drops between beats, never while a beat is on offer.
  task automatic send_request(input desu_pkg::req_t item);
    while (!steady_mode && $urandom_range(0, 99) < IDLE_PERCENT) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic issue_item(input desu_pkg::req_t item, input bit typed,
                            input desu_pkg::rsp_t known);
    bit             has_rsp;
    desu_pkg::rsp_t predicted;
    send_request(item);
    model_synapse(item, has_rsp, predicted);
    if (has_rsp) pending_tick_rsp.push_back(typed ? known : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_tick_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Spike and weight beats return nothing, so also let any of them finish.
  task automatic settle_block();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic coef_set_t phase_coefs(input int phase);
    coef_set_t c;
    if (phase == PHASE_ALL_ONES) begin
      c = '1;
    end else if (phase == PHASE_ALL_ZERO) begin
      c = '0;
    end else if (phase % 2 == 1) begin
      c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      c.rise_in   = $urandom_range(32'h0100_0000, 32'h4000_0000);
      c.rise_ret  = $urandom_range(32'h3000_0000, 32'h3FFF_FFFF);
      c.decay_in  = $urandom_range(32'h0100_0000, 32'h4000_0000);
      c.decay_ret = $urandom_range(32'h3000_0000, 32'h3FFF_FFFF);
      c.norm      = $urandom_range(32'h0000_4000, 32'h0004_0000);
      c.tstep     = $urandom;
    end
    return c;
  endfunction

  function automatic desu_pkg::req_t random_request();
    desu_pkg::req_t item;
    int             roll;
    logic [63:0]    thr;
    item.weight = $urandom;
    item.event_rate = $urandom;
    item.random_draw = $urandom;
    if ($urandom_range(0, 3) != 0)
      item.weight = 32'($urandom_range(0, SMALL_SPAN)) - SMALL_SPAN / 2;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      item.req_type = desu_pkg::REQ_WEIGHT;
    end else if (roll < 65) begin
      item.req_type = desu_pkg::REQ_SPIKE;
      // Put the draw right at the pass/fail boundary some of the time.
      thr = ({32'd0, item.event_rate} * {32'd0, coef_now.tstep}) >> FRAC;
      if ($urandom_range(0, 9) < 4 && thr < 64'h0000_0000_FFFF_FFFF)
        item.random_draw = thr[31:0] + 32'($urandom_range(0, 1));
    end else if (roll < 95) begin
      item.req_type = desu_pkg::REQ_TICK;
    end else begin
      item.req_type = desu_pkg::REQ_CLEAR;
    end
    return item;
  endfunction

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, pending_tick_rsp.size());
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= steady_mode || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    desu_pkg::rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_tick_rsp.size() == 0) begin
        $display("%0t: unexpected result beat conductance %h rise %h", $time,
                 rsp_if.data.conductance, rsp_if.data.rise_value);
        mismatch_count++;
      end else begin
        want = pending_tick_rsp.pop_front();
        if (rsp_if.data.conductance !== want.conductance) begin
          $display("%0t: conductance expected %h actual %h", $time,
                   want.conductance, rsp_if.data.conductance);
          mismatch_count++;
        end
        if (rsp_if.data.rise_value !== want.rise_value) begin
          $display("%0t: rise_value expected %h actual %h", $time,
                   want.rise_value, rsp_if.data.rise_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    desu_pkg::req_t item;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    coef_now     = '0;
    act_q        = '0;
    rise_q       = '0;
    decay_q      = '0;
    cond_q       = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == DIRECTED_CFG_ROW) begin
        settle_block();
        load_coefs(DIRECTED_COEFS, 1'b0);
      end
      item.req_type    = DIRECTED[i].kind;
      item.weight      = DIRECTED[i].weight;
      item.event_rate  = DIRECTED[i].rate;
      item.random_draw = DIRECTED[i].draw;
      issue_item(item, DIRECTED[i].typed, DIRECTED[i].known);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle_block();
      load_coefs(phase_coefs(phase), phase == PHASE_UNMAPPED);
      steady_mode = (phase == PHASE_STEADY);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((phase == PHASE_PAUSE && n == ITEMS_PER_PHASE / 2) || $urandom_range(0, 63) == 0)
          drain_results();
        issue_item(random_request(), 1'b0, '0);
      end
      steady_mode = 1'b0;
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
